>>> rtl/core/tbrl_pkg.sv
package tbrl_pkg;

  // Field and datapath widths
  localparam int unsigned NowW    = 48;
  localparam int unsigned RateW   = 30;
  localparam int unsigned BurstW  = 30;
  localparam int unsigned LevelW  = 40;
  localparam int unsigned ProdW   = NowW + RateW;
  localparam int unsigned WaitW   = 20;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // Stream payload layout
  localparam int unsigned InTdataW  = ((NowW + 7) / 8) * 8;
  localparam int unsigned OutBits   = 1 + WaitW + CountW + NowW;
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRate   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBurst  = 2'd2;

  // Reset values of the registers
  localparam logic [RateW-1:0]  RateReset  = 30'd5000;
  localparam logic [BurstW-1:0] BurstReset = 30'd5000;

  // One whole token in micro-tokens
  localparam logic [LevelW-1:0] OneToken = 40'd1000000;

  // Divider result
  typedef struct packed {
    logic [WaitW-1:0] quo;
    logic             rem_nz;
  } div_res_t;

endpackage

>>> rtl/core/tbrl_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module tbrl_mul import tbrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NowW-1:0]  a_i,
  input  logic [RateW-1:0] b_i,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(NowW);

  logic [ProdW-1:0] p_q, p_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [RateW:0]   sum;

  // Upper half accumulates b when the current multiplier bit is set
  assign sum = {1'b0, p_q[ProdW-1:NowW]} + (p_q[0] ? {1'b0, b_i} : '0);

  always_comb begin
    p_d    = p_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d   = {{RateW{1'b0}}, a_i};
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      p_d   = {sum, p_q[NowW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NowW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

>>> rtl/core/tbrl_div.sv
// Restoring divider: one quotient bit per cycle.
module tbrl_div import tbrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WaitW-1:0] dividend_i,
  input  logic [RateW-1:0] divisor_i,
  output logic             done_o,
  output div_res_t         res_o
);

  localparam int unsigned CntW = $clog2(WaitW);

  logic [RateW-1:0] rem_q, rem_d;
  logic [WaitW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [RateW:0]   trial;
  logic [RateW:0]   diff;
  logic             ge;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[WaitW-1]};
  assign ge    = (trial >= {1'b0, divisor_i});
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[RateW-1:0] : trial[RateW-1:0];
      quo_d = {quo_q[WaitW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WaitW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o        = done_q;
  assign res_o.quo     = quo_q;
  assign res_o.rem_nz  = |rem_q;

endmodule

>>> rtl/core/token_bucket_rate_limiter.sv
// Token bucket rate limiter. Each request beat carries a millisecond timestamp and
// returns one result beat: a grant flag, the wait in ms, and the running totals of
// throttled requests and waited ms. Requests are handled one at a time. With limiting
// disabled a request goes straight to the output state. With limiting enabled the
// refill product elapsed_ms * rate is formed by a bit-serial multiplier; a throttled
// request also runs the bit-serial divider for the wait. A new request is taken
// while the previous result still sits in the output register. Registers
// (limit_enable, rate_mtok_per_s, burst_mtok) must be written only while the block is
// idle; the block itself does not enforce this.
module token_bucket_rate_limiter import tbrl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Register write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [RateW-1:0]     cfg_data_i,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [47:0] now_ms
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [0] granted_now, [20:1] wait_time_ms,
                                               // [52:21] throttled_total,
                                               // [100:53] wait_total_ms, rest zero
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_TAKE   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_UPDATE = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              en_q;
  logic [RateW-1:0]  rate_q;
  logic [BurstW-1:0] burst_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [NowW-1:0]   last_q, last_d;
  logic              started_q, started_d;
  logic [CountW-1:0] thr_q, thr_d;
  logic [NowW-1:0]   wsum_q, wsum_d;
  logic [NowW-1:0]   now_q, now_d;
  logic [LevelW-1:0] cap_q, cap_d;
  logic [RateW-1:0]  rate_eff_q, rate_eff_d;
  logic              granted_q, granted_d;
  logic [WaitW-1:0]  wait_q, wait_d;
  logic              m_valid_q, m_valid_d;
  logic [OutBits-1:0] m_data_q, m_data_d;

  logic              in_acc;
  logic [LevelW-1:0] cap_calc;
  logic              mul_start, mul_done;
  logic [NowW-1:0]   elapsed;
  logic [ProdW-1:0]  prod;
  logic              div_start, div_done;
  logic [WaitW-1:0]  needed;
  div_res_t          div_res;
  logic [NowW-1:0]   base_last;
  logic [NowW:0]     diff;
  logic [LevelW:0]   refill_sum;
  logic [NowW:0]     wsum_sum;
  logic [NowW:0]     last_sum;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - OutBits){1'b0}}, m_data_q};

  // Capacity in micro-tokens: burst * 1000 = burst * (1024 - 32 + 8)
  assign cap_calc = {burst_q, 10'b0} - {5'b0, burst_q, 5'b0} + {7'b0, burst_q, 3'b0};

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      rate_q  <= RateReset;
      burst_q <= BurstReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgEnable: en_q    <= cfg_data_i[0];
        CfgRate:   rate_q  <= cfg_data_i;
        CfgBurst:  burst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tbrl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (elapsed),
    .b_i     (rate_eff_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tbrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (needed),
    .divisor_i  (rate_eff_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // Request sequencer
  always_comb begin
    state_d    = state_q;
    level_d    = level_q;
    last_d     = last_q;
    started_d  = started_q;
    thr_d      = thr_q;
    wsum_d     = wsum_q;
    now_d      = now_q;
    cap_d      = cap_q;
    rate_eff_d = rate_eff_q;
    granted_d  = granted_q;
    wait_d     = wait_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    elapsed    = '0;
    needed     = '0;
    base_last  = started_q ? last_q : now_q;
    diff       = {1'b0, now_q} - {1'b0, base_last};
    refill_sum = {1'b0, level_q} + {1'b0, prod[LevelW-1:0]};
    wsum_sum   = {1'b0, wsum_q} + {{(NowW + 1 - WaitW){1'b0}}, wait_q};
    last_sum   = {1'b0, last_q} + {{(NowW + 1 - WaitW){1'b0}}, wait_q};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          now_d      = s_axis_tdata[NowW-1:0];
          cap_d      = cap_calc;
          rate_eff_d = (rate_q == '0) ? RateW'(1) : rate_q;
          if (en_q) begin
            state_d = S_SETUP;
          end else begin
            granted_d = 1'b1;
            wait_d    = '0;
            state_d   = S_OUT;
          end
        end
      end
      // First request fills the bucket; backwards time counts as no elapsed time
      S_SETUP: begin
        if (!diff[NowW]) begin
          elapsed = diff[NowW-1:0];
          last_d  = now_q;
        end else begin
          last_d  = base_last;
        end
        level_d   = started_q ? level_q : cap_q;
        started_d = 1'b1;
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_REFILL;
        end
      end
      // Refill, clamped at the capacity
      S_REFILL: begin
        if (level_q >= cap_q || (|prod[ProdW-1:LevelW]) || refill_sum > {1'b0, cap_q}) begin
          level_d = cap_q;
        end else begin
          level_d = refill_sum[LevelW-1:0];
        end
        state_d = S_TAKE;
      end
      S_TAKE: begin
        if (level_q >= OneToken) begin
          level_d   = level_q - OneToken;
          granted_d = 1'b1;
          wait_d    = '0;
          state_d   = S_OUT;
        end else begin
          needed    = OneToken[WaitW-1:0] - level_q[WaitW-1:0];
          div_start = 1'b1;
          granted_d = 1'b0;
          state_d   = S_DIV;
        end
      end
      // Wait is the quotient rounded up
      S_DIV: begin
        if (div_done) begin
          wait_d  = div_res.quo + WaitW'(div_res.rem_nz);
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (thr_q != '1) begin
          thr_d = thr_q + 1'b1;
        end
        wsum_d  = wsum_sum[NowW] ? '1 : wsum_sum[NowW-1:0];
        last_d  = last_sum[NowW] ? '1 : last_sum[NowW-1:0];
        level_d = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {wsum_q, thr_q, wait_q, granted_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      level_q   <= '0;
      last_q    <= '0;
      started_q <= 1'b0;
      thr_q     <= '0;
      wsum_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      last_q    <= last_d;
      started_q <= started_d;
      thr_q     <= thr_d;
      wsum_q    <= wsum_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    cap_q      <= cap_d;
    rate_eff_q <= rate_eff_d;
    granted_q  <= granted_d;
    wait_q     <= wait_d;
    m_data_q   <= m_data_d;
  end

`ifndef SYNTHESIS
  // Level never above capacity once refill is done
  ap_level_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |-> (level_q <= cap_q))
    else $error("token level above capacity");

  // A granted result carries no wait, a throttled one always waits
  ap_grant_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[0] == (m_data_q[WaitW:1] == '0)))
    else $error("grant flag and wait disagree");

  // Throttle count only grows
  ap_thr_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (thr_q >= $past(thr_q)))
    else $error("throttle count went down");

  // Serial units finish only while the sequencer waits on them
  ap_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL))
    else $error("multiplier done outside multiply state");

  ap_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");
`endif

endmodule
